// ===== rtl/rcha_pkg.sv =====
package rcha_pkg;

  localparam int HANDLE_W = 8;
  localparam int TOTAL_W  = 16;
  localparam int STATUS_W = 3;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_ADD   = 2'd1,
    FN_DROP  = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_NOT_LIVE = 3'd2,
    ST_FULL     = 3'd3,
    ST_SAT      = 3'd4
  } status_t;

endpackage

// ===== rtl/rcha_ram.sv =====
module rcha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/refcounted_handle_allocator_top.sv =====
// Reference-counted handle allocator. Allocate grants the most recently freed
// handle, or the next never-used slot when none is free, with a count of one;
// add and drop move a live slot's count, and a drop from one to zero frees the
// slot. One item is accepted every clock cycle while results are taken. An
// item moves from its input register to the result register: the count and
// free-stack RAM reads are registered on the same edge as the item, and the
// update runs between that input register and the result register. The input
// stalls only while a finished item waits behind a stalled result. Both RAMs
// start uninitialized and need no clearing pass after reset: only slots
// already handed out are read.
module refcounted_handle_allocator_top #(
  parameter int NUM_SLOTS  = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        func,
  input  logic [rcha_pkg::HANDLE_W-1:0]     slot_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rcha_pkg::STATUS_W-1:0]     status,
  output logic [rcha_pkg::HANDLE_W-1:0]     result_handle,
  output logic                              slot_freed,
  output logic                              slot_live,
  output logic [rcha_pkg::TOTAL_W-1:0]      ref_total
);

  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int SU_W   = IDX_W + 1;
  localparam int HW     = rcha_pkg::HANDLE_W;
  localparam int TW     = rcha_pkg::TOTAL_W;
  localparam int CMP_W  = (SU_W > HW) ? SU_W : HW;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);
  localparam logic [SU_W-1:0] SlotsMax = SU_W'(NUM_SLOTS);

  // pipeline control
  logic                  ex_valid;
  rcha_pkg::func_t       ex_func;
  logic [HW-1:0]         ex_handle;
  logic                  ex_adv;
  logic                  in_acc;
  logic                  out_take;

  // allocator state
  logic [SU_W-1:0]       free_depth;
  logic [SU_W-1:0]       slots_used;
  logic [SU_W-1:0]       free_depth_next;
  logic [SU_W-1:0]       slots_used_next;

  // RAM ports and registered write bypass
  logic [CMP_W-1:0]      next_handle;
  logic [IDX_W-1:0]      cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  cnt_byp;
  logic [IDX_W-1:0]      cnt_byp_addr;
  logic [COUNT_BITS-1:0] cnt_byp_data;
  logic [SU_W-1:0]       stk_rptr;
  logic [IDX_W-1:0]      stk_rdata;
  logic                  stk_push;
  logic                  stk_byp;
  logic [IDX_W-1:0]      stk_byp_data;

  // execute stage
  logic [CMP_W-1:0]      h_cmp;
  logic [IDX_W-1:0]      h_idx;
  logic                  in_range;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [IDX_W-1:0]      stk_top;
  logic [IDX_W-1:0]      grant;
  rcha_pkg::status_t     st_calc;
  logic [HW-1:0]         hnd_calc;
  logic                  freed_calc;
  logic [COUNT_BITS-1:0] cnt_calc;

  assign out_take = out_valid && !out_stall;
  assign ex_adv   = ex_valid && (!out_valid || !out_stall);
  assign in_stall = ex_valid && !ex_adv;
  assign in_acc   = in_valid && !in_stall;

  // count read follows whichever item sits in execute next cycle
  assign next_handle = in_acc ? CMP_W'(slot_handle) : CMP_W'(ex_handle);
  assign cnt_raddr   = next_handle[IDX_W-1:0];
  assign stk_rptr    = free_depth_next - SU_W'(1);

  rcha_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_SLOTS)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  rcha_ram #(
    .WIDTH(IDX_W),
    .DEPTH(NUM_SLOTS)
  ) u_stk_ram (
    .clk  (clk),
    .we   (stk_push),
    .waddr(free_depth[IDX_W-1:0]),
    .wdata(h_idx),
    .raddr(stk_rptr[IDX_W-1:0]),
    .rdata(stk_rdata)
  );

  always_comb begin
    h_cmp    = CMP_W'(ex_handle);
    h_idx    = h_cmp[IDX_W-1:0];
    in_range = h_cmp < CMP_W'(slots_used);
    cnt_cur  = (cnt_byp && cnt_byp_addr == h_idx) ? cnt_byp_data : cnt_rdata;
    stk_top  = stk_byp ? stk_byp_data : stk_rdata;

    grant           = '0;
    st_calc         = rcha_pkg::ST_OK;
    hnd_calc        = ex_handle;
    freed_calc      = 1'b0;
    cnt_calc        = '0;
    cnt_we          = 1'b0;
    cnt_waddr       = h_idx;
    cnt_wdata       = '0;
    stk_push        = 1'b0;
    free_depth_next = free_depth;
    slots_used_next = slots_used;

    unique case (ex_func)
      rcha_pkg::FN_ALLOC: begin
        if (free_depth != '0 && free_depth <= SlotsMax) begin
          grant           = stk_top;
          free_depth_next = free_depth - SU_W'(1);
        end else if (slots_used < SlotsMax) begin
          grant           = slots_used[IDX_W-1:0];
          slots_used_next = slots_used + SU_W'(1);
        end else begin
          st_calc = rcha_pkg::ST_FULL;
        end
        if (st_calc == rcha_pkg::ST_OK) begin
          hnd_calc  = HW'(grant);
          cnt_calc  = CntOne;
          cnt_we    = 1'b1;
          cnt_waddr = grant;
          cnt_wdata = CntOne;
        end else begin
          hnd_calc = '0;
        end
      end
      rcha_pkg::FN_ADD: begin
        if (!in_range) begin
          st_calc = rcha_pkg::ST_RANGE;
        end else if (cnt_cur == '0) begin
          st_calc = rcha_pkg::ST_NOT_LIVE;
        end else if (cnt_cur == CntMax) begin
          st_calc  = rcha_pkg::ST_SAT;
          cnt_calc = cnt_cur;
        end else begin
          cnt_calc  = cnt_cur + CntOne;
          cnt_we    = 1'b1;
          cnt_wdata = cnt_calc;
        end
      end
      rcha_pkg::FN_DROP: begin
        if (!in_range) begin
          st_calc = rcha_pkg::ST_RANGE;
        end else if (cnt_cur == '0) begin
          st_calc = rcha_pkg::ST_NOT_LIVE;
        end else if (cnt_cur == CntOne) begin
          freed_calc = 1'b1;
          cnt_we     = 1'b1;
          if (free_depth < SlotsMax) begin
            stk_push        = 1'b1;
            free_depth_next = free_depth + SU_W'(1);
          end
        end else begin
          cnt_calc  = cnt_cur - CntOne;
          cnt_we    = 1'b1;
          cnt_wdata = cnt_calc;
        end
      end
      rcha_pkg::FN_QUERY: begin
        if (!in_range) begin
          st_calc = rcha_pkg::ST_RANGE;
        end else begin
          cnt_calc = cnt_cur;
        end
      end
      default: begin
        st_calc = rcha_pkg::ST_OK;
      end
    endcase

    // nothing commits until the item leaves execute
    if (!ex_adv) begin
      cnt_we          = 1'b0;
      stk_push        = 1'b0;
      free_depth_next = free_depth;
      slots_used_next = slots_used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid   <= 1'b0;
      out_valid  <= 1'b0;
      free_depth <= '0;
      slots_used <= '0;
      cnt_byp    <= 1'b0;
      stk_byp    <= 1'b0;
    end else begin
      free_depth <= free_depth_next;
      slots_used <= slots_used_next;
      cnt_byp    <= cnt_we;
      stk_byp    <= stk_push;
      if (in_acc) begin
        ex_valid <= 1'b1;
      end else if (ex_adv) begin
        ex_valid <= 1'b0;
      end
      if (ex_adv) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end

    if (in_acc) begin
      ex_func   <= rcha_pkg::func_t'(func);
      ex_handle <= slot_handle;
    end
    cnt_byp_addr <= cnt_waddr;
    cnt_byp_data <= cnt_wdata;
    stk_byp_data <= h_idx;
    if (ex_adv) begin
      status        <= st_calc;
      result_handle <= hnd_calc;
      slot_freed    <= freed_calc;
      slot_live     <= cnt_calc != '0;
      ref_total     <= TW'(cnt_calc);
    end
  end

  a_slots_bound : assert property (@(posedge clk) disable iff (rst)
    slots_used <= SlotsMax)
    else $error("slots_used beyond table size");

  a_free_le_used : assert property (@(posedge clk) disable iff (rst)
    free_depth <= slots_used)
    else $error("more free handles than slots ever used");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ex_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_freed_result : assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_freed |-> status == rcha_pkg::ST_OK && !slot_live && ref_total == '0)
    else $error("freed slot reported with a live count");

  a_push_grows : assert property (@(posedge clk) disable iff (rst)
    stk_push |=> free_depth == $past(free_depth) + SU_W'(1))
    else $error("free stack push lost");

endmodule

// ===== dv/handle_table_sb_pkg.sv =====
`timescale 1ns / 100ps
package handle_table_sb_pkg;

  typedef struct packed {
    rcha_pkg::status_t                  st;
    logic [rcha_pkg::HANDLE_W-1:0]      handle;
    logic                               freed;
    logic                               live;
    logic [rcha_pkg::TOTAL_W-1:0]       total;
  } reply_t;

  class handle_table_scoreboard;
    localparam int unsigned NSLOTS    = 256;
    localparam logic [rcha_pkg::TOTAL_W-1:0] COUNT_MAX = '1;

    logic [rcha_pkg::TOTAL_W-1:0]  slot_count [NSLOTS];
    logic [rcha_pkg::HANDLE_W-1:0] free_lifo [NSLOTS];
    int unsigned         lifo_depth;
    int unsigned         slots_taken;
    reply_t              pending_replies[$];
    int unsigned         mismatches;

    function new();
      lifo_depth  = 0;
      slots_taken = 0;
      mismatches  = 0;
    endfunction

    // Updates the table copy for one accepted item and queues the reply it causes.
    function void note_request(rcha_pkg::func_t f, logic [rcha_pkg::HANDLE_W-1:0] h);
      reply_t r;
      logic [rcha_pkg::HANDLE_W-1:0] g;
      logic [rcha_pkg::TOTAL_W-1:0] c;
      r.st     = rcha_pkg::ST_OK;
      r.handle = h;
      r.freed  = 1'b0;
      r.live   = 1'b0;
      r.total  = '0;
      if (f == rcha_pkg::FN_ALLOC) begin
        if (lifo_depth > 0) begin
          lifo_depth--;
          g = free_lifo[lifo_depth];
        end else if (slots_taken < NSLOTS) begin
          g = slots_taken[rcha_pkg::HANDLE_W-1:0];
          slots_taken++;
        end else begin
          r.st     = rcha_pkg::ST_FULL;
          r.handle = '0;
          pending_replies.push_back(r);
          return;
        end
        slot_count[g] = rcha_pkg::TOTAL_W'(1);
        r.handle = g;
        r.live   = 1'b1;
        r.total  = rcha_pkg::TOTAL_W'(1);
      end else if (h >= slots_taken) begin
        r.st = rcha_pkg::ST_RANGE;
      end else begin
        c = slot_count[h];
        case (f)
          rcha_pkg::FN_ADD: begin
            if (c == 0) begin
              r.st = rcha_pkg::ST_NOT_LIVE;
            end else if (c == COUNT_MAX) begin
              r.st    = rcha_pkg::ST_SAT;
              r.live  = 1'b1;
              r.total = c;
            end else begin
              c++;
              slot_count[h] = c;
              r.live  = 1'b1;
              r.total = c;
            end
          end
          rcha_pkg::FN_DROP: begin
            if (c == 0) begin
              r.st = rcha_pkg::ST_NOT_LIVE;
            end else if (c == 1) begin
              slot_count[h] = '0;
              if (lifo_depth < NSLOTS) begin
                free_lifo[lifo_depth] = h;
                lifo_depth++;
              end
              r.freed = 1'b1;
            end else begin
              c--;
              slot_count[h] = c;
              r.live  = 1'b1;
              r.total = c;
            end
          end
          default: begin
            r.live  = (c != 0);
            r.total = c;
          end
        endcase
      end
      pending_replies.push_back(r);
    endfunction

    function void check_result(logic [rcha_pkg::STATUS_W-1:0] st,
                               logic [rcha_pkg::HANDLE_W-1:0] hd,
                               logic fr, logic lv, logic [rcha_pkg::TOTAL_W-1:0] tot);
      reply_t e;
      if (pending_replies.size() == 0) begin
        $error("result with no item outstanding: status %0d handle %0d", st, hd);
        mismatches++;
        return;
      end
      e = pending_replies.pop_front();
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        mismatches++;
      end
      if (hd !== e.handle) begin
        $error("result_handle: expected %0d, got %0d", e.handle, hd);
        mismatches++;
      end
      if (fr !== e.freed) begin
        $error("slot_freed: expected %0d, got %0d", e.freed, fr);
        mismatches++;
      end
      if (lv !== e.live) begin
        $error("slot_live: expected %0d, got %0d", e.live, lv);
        mismatches++;
      end
      if (tot !== e.total) begin
        $error("ref_total: expected %0d, got %0d", e.total, tot);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== dv/refcounted_handle_allocator_top_test.sv =====
`timescale 1ns / 100ps
module refcounted_handle_allocator_top_test;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    func;
  logic [rcha_pkg::HANDLE_W-1:0] slot_handle;
  logic                          out_valid;
  logic                          out_stall;
  logic [rcha_pkg::STATUS_W-1:0] status;
  logic [rcha_pkg::HANDLE_W-1:0] result_handle;
  logic                          slot_freed;
  logic                          slot_live;
  logic [rcha_pkg::TOTAL_W-1:0]  ref_total;

  bit          calm = 1'b0;       // no idling on either side
  bit          hold_long = 1'b0;  // receiver takes one long hold-off
  int unsigned cycle_count = 0;

  handle_table_sb_pkg::handle_table_scoreboard sb = new();

  refcounted_handle_allocator_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .slot_handle   (slot_handle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .result_handle (result_handle),
    .slot_freed    (slot_freed),
    .slot_live     (slot_live),
    .ref_total     (ref_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, result_handle, slot_freed, slot_live, ref_total);
  end

  // Receiver side: random stall bursts, plus one long hold-off on request.
  initial begin : rx_stall
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_item(input rcha_pkg::func_t f,
                           input logic [rcha_pkg::HANDLE_W-1:0] h);
    int n;
    in_valid    <= 1'b1;
    func        <= f;
    slot_handle <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(f, h);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_replies.size() != 0) @(negedge clk);
  endtask

  // Mostly handles already handed out, some just past the end, some anywhere.
  function automatic logic [rcha_pkg::HANDLE_W-1:0] pick_handle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sb.slots_taken != 0 && r < 75)
      return rcha_pkg::HANDLE_W'($urandom_range(0, sb.slots_taken - 1));
    if (r < 85)
      return rcha_pkg::HANDLE_W'(sb.slots_taken);
    return rcha_pkg::HANDLE_W'($urandom);
  endfunction

  task automatic run_random(input int count, input int w_alloc, input int w_add,
                            input int w_drop);
    int r;
    rcha_pkg::func_t f;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_alloc)
        f = rcha_pkg::FN_ALLOC;
      else if (r < w_alloc + w_add)
        f = rcha_pkg::FN_ADD;
      else if (r < w_alloc + w_add + w_drop)
        f = rcha_pkg::FN_DROP;
      else
        f = rcha_pkg::FN_QUERY;
      send_item(f, (f == rcha_pkg::FN_ALLOC) ? rcha_pkg::HANDLE_W'($urandom)
                                             : pick_handle());
    end
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    in_valid    = 1'b0;
    func        = rcha_pkg::FN_ALLOC;
    slot_handle = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, then grant / count / free / LIFO reuse
    send_item(rcha_pkg::FN_QUERY, 8'd0);
    send_item(rcha_pkg::FN_ADD,   8'hFF);
    send_item(rcha_pkg::FN_DROP,  8'd0);
    send_item(rcha_pkg::FN_ALLOC, 8'hFF);
    send_item(rcha_pkg::FN_ALLOC, 8'd0);
    send_item(rcha_pkg::FN_ADD,   8'd0);
    send_item(rcha_pkg::FN_DROP,  8'd0);
    send_item(rcha_pkg::FN_DROP,  8'd0);
    send_item(rcha_pkg::FN_DROP,  8'd0);
    send_item(rcha_pkg::FN_ADD,   8'd0);
    send_item(rcha_pkg::FN_QUERY, 8'd0);
    send_item(rcha_pkg::FN_QUERY, 8'd1);
    send_item(rcha_pkg::FN_ALLOC, 8'h55);
    send_item(rcha_pkg::FN_DROP,  8'd1);
    send_item(rcha_pkg::FN_DROP,  8'd0);
    send_item(rcha_pkg::FN_ALLOC, 8'hAA);
    send_item(rcha_pkg::FN_ALLOC, 8'd0);
    send_item(rcha_pkg::FN_ALLOC, 8'd0);
    send_item(rcha_pkg::FN_ADD,   8'd2);
    send_item(rcha_pkg::FN_ADD,   8'd3);
    send_item(rcha_pkg::FN_QUERY, 8'h80);
    wait_drained();

    // allocate-heavy: fills the table and hits the full case
    run_random(600, 65, 15, 10);
    wait_drained();

    // drop-heavy, with the output held off for a while at the start
    hold_long = 1'b1;
    run_random(450, 15, 10, 60);
    wait_drained();

    calm = 1'b1;
    run_random(350, 30, 25, 30);
    wait_drained();
    repeat (8) @(negedge clk);

    if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== refcounted_handle_allocator_top.f =====
rtl/rcha_pkg.sv
rtl/rcha_ram.sv
rtl/refcounted_handle_allocator_top.sv
dv/handle_table_sb_pkg.sv
dv/refcounted_handle_allocator_top_test.sv
